@@ design/two_button_touch_gesture_fsm_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the touch gesture block
// Concurrent assertion wrappers used by the checker file tbg_checker.sv.
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_TOUCH_GESTURE_FSM_ASSERT_SVH
`define TWO_BUTTON_TOUCH_GESTURE_FSM_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define TBG_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define TBG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/tbg_pkg.sv @@
// ----------------------------------------------------------------------------
// tbg_pkg
// Types, codes and reset constants for the two-button touch gesture block.
// ----------------------------------------------------------------------------
package tbg_pkg;

  localparam int unsigned CFG_W           = 16;
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  localparam logic [CFG_W-1:0] TAP_TICKS_RST   = 16'd250;
  localparam logic [CFG_W-1:0] PRESS_TICKS_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_TICKS_RST  = 16'd9500;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_TRIG  = 4'd1,
    ST_TAP   = 4'd2,
    ST_TAP2  = 4'd3,
    ST_PRESS = 4'd4,
    ST_LONG  = 4'd5,
    ST_SLID  = 4'd6,
    ST_BOTH  = 4'd7,
    ST_BLONG = 4'd8
  } tbg_state_e;

  typedef enum logic [2:0] {
    G_TAP        = 3'd0,
    G_DOUBLE_TAP = 3'd1,
    G_PRESS      = 3'd2,
    G_LONG_PRESS = 3'd3,
    G_PRESS_BOTH = 3'd4,
    G_LONG_BOTH  = 3'd5,
    G_SLIDE_LR   = 3'd6,
    G_SLIDE_RL   = 3'd7
  } tbg_gesture_e;

  typedef enum logic [1:0] {
    MODE_BUTTON = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_PROX   = 2'd2
  } tbg_mode_e;

  typedef enum logic [1:0] {
    CFG_TAP   = 2'd0,
    CFG_PRESS = 2'd1,
    CFG_LONG  = 2'd2
  } tbg_cfg_e;

  typedef struct packed {
    logic [CFG_W-1:0] tap_ticks;
    logic [CFG_W-1:0] press_ticks;
    logic [CFG_W-1:0] long_ticks;
  } tbg_cfg_t;

  typedef struct packed {
    logic         gesture_valid;
    tbg_gesture_e gesture;
    tbg_state_e   fsm_state;
  } tbg_result_t;

endpackage

@@ design/two_button_touch_gesture_fsm.sv @@
// ----------------------------------------------------------------------------
// two_button_touch_gesture_fsm
// Gesture recogniser for two touch buttons with a tick-driven one-shot timer.
// ----------------------------------------------------------------------------
// Input stream: one word per button event, timer tick or proximity event.
//   s_axis_tuser carries the mode, s_axis_tdata the pressed-button status.
// Output stream: one word per input word, carrying the gesture flag in
//   m_axis_tuser and the gesture code and state after the step in tdata.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write tap, press and
//   long tick counts; always ready; the user must write them only while
//   the block is idle; the block does not enforce it.
// Throughput: one word per cycle unless the buffer is full; the state machine
//   and timer compare resolve in one pass of logic before a two-word buffer.
// Stall: the buffer holds up to two words while the sink holds tready low;
//   s_axis_tready drops only when both entries are occupied.
// Reset: state idle, timer stopped, buffer empty, tick counts at defaults.
// ----------------------------------------------------------------------------
module two_button_touch_gesture_fsm #(
  parameter int unsigned TIMER_WIDTH = tbg_pkg::TIMER_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [1:0] button_status, [7:2] zero
  input  logic [1:0]               s_axis_tuser,   // [1:0] mode
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [2:0] gesture, [6:3] fsm_state, [7] zero
  output logic                     m_axis_tuser,   // [0] gesture_valid
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [tbg_pkg::CFG_W-1:0] cfg_data_i
);
  import tbg_pkg::*;

  tbg_cfg_t    cfg_q;
  tbg_result_t result;
  tbg_result_t buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        in_fire, out_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_ticks   <= TAP_TICKS_RST;
      cfg_q.press_ticks <= PRESS_TICKS_RST;
      cfg_q.long_ticks  <= LONG_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TAP:   cfg_q.tap_ticks   <= cfg_data_i;
        CFG_PRESS: cfg_q.press_ticks <= cfg_data_i;
        CFG_LONG:  cfg_q.long_ticks  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = m_axis_tvalid & m_axis_tready;

  tbg_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_fire),
    .mode_i   (s_axis_tuser),
    .status_i (s_axis_tdata[1:0]),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_fire)  wr_ptr_q <= ~wr_ptr_q;
      if (out_fire) rd_ptr_q <= ~rd_ptr_q;
      if (in_fire && !out_fire) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (out_fire && !in_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) buf_q[wr_ptr_q] <= result;
  end

  assign m_axis_tdata = {1'b0, buf_q[rd_ptr_q].fsm_state, buf_q[rd_ptr_q].gesture};
  assign m_axis_tuser = buf_q[rd_ptr_q].gesture_valid;

endmodule

@@ design/tbg_core.sv @@
// ----------------------------------------------------------------------------
// tbg_core
// Gesture state machine and one-shot tick timer; one word per cycle while en_i is high.
// ----------------------------------------------------------------------------
module tbg_core #(
  parameter int unsigned TIMER_WIDTH = tbg_pkg::TIMER_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [1:0]          mode_i,
  input  logic [1:0]          status_i,
  input  tbg_pkg::tbg_cfg_t   cfg_i,
  output tbg_pkg::tbg_result_t result_o
);
  import tbg_pkg::*;

  tbg_state_e             state_q, state_d;
  logic [TIMER_WIDTH-1:0] count_q, count_d;
  logic [TIMER_WIDTH-1:0] limit_q, limit_d;
  logic                   run_q, run_d;
  logic [1:0]             first_q, first_d;
  logic [1:0]             second_q, second_d;
  logic [TIMER_WIDTH-1:0] count_inc;
  logic                   gv;
  tbg_gesture_e           gest;

  assign count_inc = count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      limit_q  <= '0;
      run_q    <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
    end else if (en_i) begin
      state_q  <= state_d;
      count_q  <= count_d;
      limit_q  <= limit_d;
      run_q    <= run_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    limit_d  = limit_q;
    run_d    = run_q;
    first_d  = first_q;
    second_d = second_q;
    gv       = 1'b0;
    gest     = G_TAP;
    case (mode_i)
      MODE_BUTTON: begin
        unique case (state_q)
          ST_TRIG: begin
            second_d = status_i;
            count_d  = '0;
            run_d    = 1'b1;
            if (status_i != 2'd0) begin
              state_d = ST_BOTH;
              limit_d = TIMER_WIDTH'(cfg_i.long_ticks);
            end else begin
              state_d = ST_TAP;
              limit_d = TIMER_WIDTH'(cfg_i.tap_ticks);
            end
          end
          ST_TAP: begin
            run_d    = 1'b0;
            second_d = status_i;
            state_d  = (status_i != first_q) ? ST_SLID : ST_TAP2;
          end
          ST_TAP2: begin
            state_d = ST_IDLE;
            run_d   = 1'b0;
            gv      = 1'b1;
            gest    = G_DOUBLE_TAP;
          end
          ST_PRESS: begin
            second_d = status_i;
            if (status_i != 2'd0) begin
              state_d = ST_BOTH;
              count_d = '0;
              limit_d = TIMER_WIDTH'(cfg_i.long_ticks);
              run_d   = 1'b1;
            end else begin
              state_d = ST_IDLE;
              run_d   = 1'b0;
              gv      = 1'b1;
              gest    = G_PRESS;
            end
          end
          ST_LONG: begin
            state_d = ST_IDLE;
            run_d   = 1'b0;
            gv      = 1'b1;
            gest    = G_LONG_PRESS;
          end
          ST_SLID: begin
            state_d = ST_IDLE;
            gv      = 1'b1;
            gest    = (first_q < second_q) ? G_SLIDE_LR : G_SLIDE_RL;
          end
          ST_BOTH: begin
            run_d = 1'b0;
            if (status_i == 2'd0) begin
              state_d = ST_IDLE;
              gv      = 1'b1;
              gest    = G_PRESS_BOTH;
            end
          end
          ST_BLONG: begin
            if (status_i == 2'd0) begin
              state_d = ST_IDLE;
              gv      = 1'b1;
              gest    = G_LONG_BOTH;
            end
          end
          default: begin
            state_d = ST_IDLE;
            first_d = status_i;
            if (status_i == 2'b11) begin
              state_d = ST_BOTH;
              count_d = '0;
              limit_d = TIMER_WIDTH'(cfg_i.long_ticks);
              run_d   = 1'b1;
            end else if (status_i != 2'd0) begin
              state_d = ST_TRIG;
              count_d = '0;
              limit_d = TIMER_WIDTH'(cfg_i.press_ticks);
              run_d   = 1'b1;
            end
          end
        endcase
      end
      MODE_TICK: begin
        if (run_q) begin
          count_d = count_inc;
          if (count_inc >= limit_q) begin
            run_d = 1'b0;
            unique case (state_q)
              ST_TRIG: begin
                state_d = ST_PRESS;
                count_d = '0;
                limit_d = TIMER_WIDTH'(cfg_i.long_ticks);
                run_d   = 1'b1;
              end
              ST_TAP: begin
                state_d = ST_IDLE;
                gv      = 1'b1;
                gest    = G_TAP;
              end
              ST_PRESS: state_d = ST_LONG;
              ST_BOTH:  state_d = ST_BLONG;
              default:  ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.gesture_valid = gv;
  assign result_o.gesture       = gv ? gest : G_TAP;
  assign result_o.fsm_state     = state_d;

endmodule

@@ design/tbg_checker.sv @@
// ----------------------------------------------------------------------------
// tbg_checker
// Port-level checks on the gesture block, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_button_touch_gesture_fsm_assert.svh"

module tbg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [7:0]                s_axis_tdata,
  input logic [1:0]                s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [7:0]                m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [1:0]                cfg_index_i,
  input logic [tbg_pkg::CFG_W-1:0] cfg_data_i
);
  import tbg_pkg::*;

  logic unused_in;
  assign unused_in = ^{s_axis_tvalid, s_axis_tdata, s_axis_tuser, cfg_valid_i,
                       cfg_ready_o, cfg_index_i, cfg_data_i};

  // a word on offer stays until taken
  `TBG_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word dropped or changed")

  // a gesture always finishes back in idle
  `TBG_ASSERT(a_gesture_idle, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[6:3] == ST_IDLE, "gesture outside idle")

  // no gesture flag, no code
  `TBG_ASSERT(a_gesture_zero, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2:0] == G_TAP, "stray gesture code")

  // input back-pressure never with an empty output buffer
  `TBG_ASSERT(a_stall_full, clk_i, rst_ni,
    !s_axis_tready |-> m_axis_tvalid, "stalled with empty output")

  // buffer empty while reset is asserted
  `TBG_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |-> !m_axis_tvalid, "output valid in reset")

endmodule

bind two_button_touch_gesture_fsm tbg_checker u_tbg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);

@@ sim/tbg_gesture_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tbg_gesture_checker
// Watches the configuration, input and output channels of the touch gesture
// block, predicts every output word from the accepted input words and the
// tick counts written, and compares each output word with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module tbg_gesture_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [1:0] button_status, [7:2] zero
  input  logic [1:0]                s_axis_tuser,   // [1:0] mode
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [7:0]                m_axis_tdata,   // [2:0] gesture, [6:3] fsm_state, [7] zero
  input  logic                      m_axis_tuser,   // [0] gesture_valid
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [tbg_pkg::CFG_W-1:0] cfg_data_i,
  output int                        mismatches_o,
  output int                        pending_o
);
  import tbg_pkg::*;

  localparam int unsigned TW        = TIMER_WIDTH_DEF;
  localparam logic [1:0]  NONE_DOWN = 2'b00;
  localparam logic [1:0]  BOTH_DOWN = 2'b11;

  tbg_cfg_t      ticks_cfg;
  tbg_state_e    gst;
  logic [TW-1:0] t_cnt;
  logic [TW-1:0] t_lim;
  logic          t_run;
  logic [1:0]    first_st;
  logic [1:0]    second_st;
  tbg_result_t   expected_gestures[$];
  int            mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic void arm_timer(logic [CFG_W-1:0] ticks);
    t_cnt = '0;
    t_lim = ticks;
    t_run = 1'b1;
  endfunction

  function automatic tbg_result_t gesture_step(logic [1:0] mode, logic [1:0] st);
    tbg_result_t  r;
    logic         hit;
    tbg_gesture_e g;
    hit = 1'b0;
    g   = G_TAP;
    if (mode == MODE_BUTTON) begin
      case (gst)
        ST_TRIG: begin
          second_st = st;
          if (st != NONE_DOWN) begin
            gst = ST_BOTH;
            arm_timer(ticks_cfg.long_ticks);
          end else begin
            gst = ST_TAP;
            arm_timer(ticks_cfg.tap_ticks);
          end
        end
        ST_TAP: begin
          t_run     = 1'b0;
          second_st = st;
          gst       = (st != first_st) ? ST_SLID : ST_TAP2;
        end
        ST_TAP2: begin
          gst   = ST_IDLE;
          t_run = 1'b0;
          hit   = 1'b1;
          g     = G_DOUBLE_TAP;
        end
        ST_PRESS: begin
          second_st = st;
          if (st != NONE_DOWN) begin
            gst = ST_BOTH;
            arm_timer(ticks_cfg.long_ticks);
          end else begin
            gst   = ST_IDLE;
            t_run = 1'b0;
            hit   = 1'b1;
            g     = G_PRESS;
          end
        end
        ST_LONG: begin
          gst   = ST_IDLE;
          t_run = 1'b0;
          hit   = 1'b1;
          g     = G_LONG_PRESS;
        end
        ST_SLID: begin
          gst = ST_IDLE;
          hit = 1'b1;
          g   = (first_st < second_st) ? G_SLIDE_LR : G_SLIDE_RL;
        end
        ST_BOTH: begin
          // partial release only stops the timer
          t_run = 1'b0;
          if (st == NONE_DOWN) begin
            gst = ST_IDLE;
            hit = 1'b1;
            g   = G_PRESS_BOTH;
          end
        end
        ST_BLONG: begin
          if (st == NONE_DOWN) begin
            gst = ST_IDLE;
            hit = 1'b1;
            g   = G_LONG_BOTH;
          end
        end
        default: begin
          gst      = ST_IDLE;
          first_st = st;
          if (st == BOTH_DOWN) begin
            gst = ST_BOTH;
            arm_timer(ticks_cfg.long_ticks);
          end else if (st != NONE_DOWN) begin
            gst = ST_TRIG;
            arm_timer(ticks_cfg.press_ticks);
          end
        end
      endcase
    end else if (mode == MODE_TICK && t_run) begin
      t_cnt = t_cnt + 1'b1;
      if (t_cnt >= t_lim) begin
        t_run = 1'b0;
        case (gst)
          ST_TRIG: begin
            gst = ST_PRESS;
            arm_timer(ticks_cfg.long_ticks);
          end
          ST_TAP: begin
            gst = ST_IDLE;
            hit = 1'b1;
            g   = G_TAP;
          end
          ST_PRESS: gst = ST_LONG;
          ST_BOTH:  gst = ST_BLONG;
          default: ;
        endcase
      end
    end
    r.gesture_valid = hit;
    r.gesture       = g;
    r.fsm_state     = gst;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tbg_result_t got;
    tbg_result_t want;
    if (!rst_ni) begin
      ticks_cfg.tap_ticks   = TAP_TICKS_RST;
      ticks_cfg.press_ticks = PRESS_TICKS_RST;
      ticks_cfg.long_ticks  = LONG_TICKS_RST;
      gst                   = ST_IDLE;
      t_cnt                 = '0;
      t_lim                 = '0;
      t_run                 = 1'b0;
      first_st              = NONE_DOWN;
      second_st             = NONE_DOWN;
      expected_gestures.delete();
      pending_o <= 0;
    end else begin
      // a word taken at the same edge as a write still sees the old counts
      if (s_axis_tvalid && s_axis_tready)
        expected_gestures.push_back(gesture_step(s_axis_tuser, s_axis_tdata[1:0]));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TAP:   ticks_cfg.tap_ticks   = cfg_data_i;
          CFG_PRESS: ticks_cfg.press_ticks = cfg_data_i;
          CFG_LONG:  ticks_cfg.long_ticks  = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.gesture_valid = m_axis_tuser;
        got.gesture       = tbg_gesture_e'(m_axis_tdata[2:0]);
        got.fsm_state     = tbg_state_e'(m_axis_tdata[6:3]);
        if (expected_gestures.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word: valid=%0b gesture=%0d state=%0d",
                     $time, got.gesture_valid, got.gesture, got.fsm_state);
        end else begin
          want = expected_gestures.pop_front();
          if (got.gesture_valid !== want.gesture_valid || got.gesture !== want.gesture ||
              got.fsm_state !== want.fsm_state) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected valid=%0b gesture=%0d state=%0d, got valid=%0b gesture=%0d state=%0d",
                       $time, want.gesture_valid, want.gesture, want.fsm_state,
                       got.gesture_valid, got.gesture, got.fsm_state);
          end
        end
      end
      pending_o <= expected_gestures.size();
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the two-button touch gesture block. A directed run covers
// all gestures but press and right-to-left slide, and timer corner cases;
// random gesture sequences with noise run under several tick settings and
// idle gaps and output stalls; a checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb;
  import tbg_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;        // [1:0] button_status, [7:2] zero
  logic [1:0]       s_axis_tuser  = MODE_PROX; // [1:0] mode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;              // [2:0] gesture, [6:3] fsm_state, [7] zero
  logic             m_axis_tuser;              // [0] gesture_valid
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i   = CFG_TAP;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  int mismatches;
  int pending;
  int words_sent     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int burst_max      = 8;

  two_button_touch_gesture_fsm DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  tbg_gesture_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
  end

  initial begin
    #400_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic push_word(logic [1:0] mode, logic [1:0] status);
    if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'd0, status};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode == MODE_BUTTON || mode == MODE_TICK) words_sent++;
  endtask

  task automatic tick_burst();
    logic [1:0] st;
    repeat ($urandom_range(burst_max, 0)) begin
      st = 2'($urandom_range(3, 0));
      push_word(MODE_TICK, st);
    end
  endtask

  task automatic write_reg(tbg_cfg_e idx, logic [CFG_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_ticks(logic [CFG_W-1:0] tap_v, logic [CFG_W-1:0] press_v,
                               logic [CFG_W-1:0] long_v);
    cfg_valid_i <= 1'b1;
    write_reg(CFG_TAP, tap_v);
    write_reg(CFG_PRESS, press_v);
    write_reg(CFG_LONG, long_v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly well-formed press/release sequences with tick bursts, some noise
  task automatic gesture_phase(int n_words);
    int         stop_at;
    int         roll;
    logic [1:0] first;
    logic [1:0] st;
    logic [1:0] m;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      roll = $urandom_range(99, 0);
      if (roll < 12) begin
        m  = 2'($urandom_range(3, 0));
        st = 2'($urandom_range(3, 0));
        push_word(m, st);
      end else begin
        roll  = $urandom_range(99, 0);
        first = (roll < 40) ? 2'd1 : (roll < 80) ? 2'd2 : 2'd3;
        push_word(MODE_BUTTON, first);
        repeat ($urandom_range(3, 1)) begin
          tick_burst();
          roll = $urandom_range(9, 0);
          if (roll < 4)
            st = 2'd0;
          else if (roll < 7)
            st = first;
          else
            st = 2'($urandom_range(3, 0));
          push_word(MODE_BUTTON, st);
        end
        tick_burst();
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] tap_v;
    logic [CFG_W-1:0] press_v;
    logic [CFG_W-1:0] long_v;
    int               phase_len;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tick counts: proximity, unused mode, stopped timer, release in idle
    push_word(MODE_PROX, 2'd1);
    push_word(MODE_UNUSED, 2'd3);
    push_word(MODE_TICK, 2'd2);
    push_word(MODE_BUTTON, 2'd0);
    drain();

    program_ticks(16'd1, 16'd1, 16'd1);
    // tap
    push_word(MODE_BUTTON, 2'd1); push_word(MODE_BUTTON, 2'd0); push_word(MODE_TICK, 2'd0);
    // double tap
    push_word(MODE_BUTTON, 2'd1); push_word(MODE_BUTTON, 2'd0);
    push_word(MODE_BUTTON, 2'd1); push_word(MODE_BUTTON, 2'd0);
    // long press via press
    push_word(MODE_BUTTON, 2'd2); push_word(MODE_TICK, 2'd0);
    push_word(MODE_TICK, 2'd0);   push_word(MODE_BUTTON, 2'd0);
    // both pressed, partial release stops the timer, tick then ignored
    push_word(MODE_BUTTON, 2'd3); push_word(MODE_BUTTON, 2'd2);
    push_word(MODE_TICK, 2'd0);   push_word(MODE_BUTTON, 2'd0);
    // long both with a partial release on the way
    push_word(MODE_BUTTON, 2'd3); push_word(MODE_TICK, 2'd0);
    push_word(MODE_BUTTON, 2'd1); push_word(MODE_BUTTON, 2'd0);
    // slide left to right
    push_word(MODE_BUTTON, 2'd1); push_word(MODE_BUTTON, 2'd0);
    push_word(MODE_BUTTON, 2'd2); push_word(MODE_BUTTON, 2'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      tap_v          = CFG_W'($urandom_range(6, 1));
      press_v        = CFG_W'($urandom_range(6, 1));
      long_v         = CFG_W'($urandom_range(6, 1));
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      phase_len      = 160;
      burst_max      = $urandom_range(12, 6);
      case (ph)
        1: src_idle_pct = 87;
        2: begin
          sink_stall_pct = 87;
          tap_v          = '1;
          press_v        = '1;
          long_v         = '1;
          phase_len      = 100;
        end
        3: begin
          src_idle_pct   = 8;
          sink_stall_pct = 8;
        end
        4: begin
          tap_v     = '1;
          press_v   = 16'd1;
          phase_len = 100;
        end
        default: ;
      endcase
      program_ticks(tap_v, press_v, long_v);
      gesture_phase(phase_len);
      drain();
    end

    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tbg_pkg.sv
design/tbg_core.sv
design/two_button_touch_gesture_fsm.sv
design/tbg_checker.sv
sim/tbg_gesture_checker.sv
sim/tb.sv
